// ===== hdl/mbpscan_pkg.sv =====
package mbpscan_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int LEN_W     = 5;
    localparam int LEN_MAX   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int CARE_W    = 16;
    localparam int PAT_W     = LEN_MAX * BYTE_W;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_PATTERN_LEN  = 3'd3
    } t_cfg_idx;

    // Pattern set-up as seen by the comparator
    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [CARE_W-1:0] care;
        logic [LEN_W-1:0]  len;
    } t_cfg;

    // One scan step handed to the window
    typedef struct packed {
        logic advance;
        logic last;
        logic found;
    } t_step;

endpackage

// ===== hdl/mbpscan_in_if.sv =====
interface mbpscan_in_if
    import mbpscan_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_region;

    modport source (output valid, output data_byte, output end_of_region, input ready);
    modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

// ===== hdl/mbpscan_out_if.sv =====
interface mbpscan_out_if
    import mbpscan_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               match_found;
    logic [COUNT_W-1:0] match_offset;

    modport source (output valid, output match_found, output match_offset, input ready);
    modport sink   (input valid, input match_found, input match_offset, output ready);
endinterface

// ===== hdl/mbpscan_cfg.sv =====
module mbpscan_cfg
    import mbpscan_pkg::*;
#(
    parameter int WIN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [CFG_W-1:0]  r_pat_lo;
    logic [CFG_W-1:0]  r_pat_hi;
    logic [CARE_W-1:0] r_care;
    logic [LEN_W-1:0]  r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '1;
            r_len    <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                CFG_CARE_MASK:    r_care   <= i_cfg_data[CARE_W-1:0];
                CFG_PATTERN_LEN:  r_len    <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp length into 1..window depth
    always_comb begin
        o_cfg.pattern = {r_pat_hi, r_pat_lo};
        o_cfg.care    = r_care;
        if (r_len == '0) begin
            o_cfg.len = LEN_W'(1);
        end else if (r_len > LEN_W'(WIN)) begin
            o_cfg.len = LEN_W'(WIN);
        end else begin
            o_cfg.len = r_len;
        end
    end

endmodule

// ===== hdl/mbpscan_window.sv =====
module mbpscan_window
    import mbpscan_pkg::*;
#(
    parameter int WIN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step              i_step,
    input  logic [BYTE_W-1:0]  i_byte,
    output logic [BYTE_W-1:0]  o_win_next [WIN],
    output logic [COUNT_W-1:0] o_seen_next,
    output logic               o_matched
);

    logic [BYTE_W-1:0]  r_win [WIN];
    logic [COUNT_W-1:0] r_seen;
    logic               r_matched;
    logic [BYTE_W-1:0]  n_win [WIN];

    // Newest byte lands at entry 0, older ones move up
    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < WIN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign o_win_next  = n_win;
    assign o_seen_next = (r_seen == COUNT_SAT) ? r_seen : r_seen + COUNT_W'(1);
    assign o_matched   = r_matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= '0;
            end
            r_seen    <= '0;
            r_matched <= 1'b0;
        end else if (i_step.advance) begin
            if (i_step.last) begin
                for (int k = 0; k < WIN; k++) begin
                    r_win[k] <= '0;
                end
                r_seen    <= '0;
                r_matched <= 1'b0;
            end else begin
                r_win     <= n_win;
                r_seen    <= o_seen_next;
                r_matched <= r_matched | i_step.found;
            end
        end
    end

endmodule

// ===== hdl/mbpscan_match.sv =====
module mbpscan_match
    import mbpscan_pkg::*;
#(
    parameter int WIN = 16
) (
    input  t_cfg              i_cfg,
    input  logic [BYTE_W-1:0] i_win [WIN],
    output logic              o_hit
);

    localparam int IDX_W = (WIN > 1) ? $clog2(WIN) : 1;

    // Pattern byte j lines up with the window byte that is len-1-j old
    always_comb begin
        logic [LEN_W-1:0] diff;
        logic [IDX_W-1:0] idx;
        o_hit = 1'b1;
        for (int j = 0; j < WIN; j++) begin
            diff = i_cfg.len - LEN_W'(1) - LEN_W'(j);
            idx  = diff[IDX_W-1:0];
            if (LEN_W'(j) < i_cfg.len && i_cfg.care[j] &&
                i_cfg.pattern[BYTE_W*j +: BYTE_W] != i_win[idx]) begin
                o_hit = 1'b0;
            end
        end
    end

endmodule

// ===== hdl/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner.
// Bytes of a scanned region arrive one per beat on i_in (data_byte, with
// end_of_region set on the last byte of a scan). Each byte is compared, as the
// newest byte of a window, with the configured pattern; care_mask bits that are
// clear mark wildcard positions. The first full match of a scan gives one beat
// on o_out with match_found set and the start offset of the match. A scan that
// ends with no match gives one beat with match_found clear and offset zero.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must do so only while the block is idle, which the block does not
// enforce; indexes beyond the register list are dropped. Throughput: one byte
// per cycle while o_out is not stalled. An accepted byte goes from the input
// register through a single compare stage into the result register. Reset
// (synchronous, active low) clears the window, byte count, match flag and the
// valid flags of both pipeline registers, and loads the configuration defaults.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; further bytes wait until o_out is taken.
module masked_byte_pattern_scanner
    import mbpscan_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mbpscan_in_if.sink           i_in,
    mbpscan_out_if.source        o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Window depth never exceeds the pattern register width
    localparam int WIN = (PATTERN_MAX < LEN_MAX) ? PATTERN_MAX : LEN_MAX;

    t_cfg               cfg;
    t_step              step;
    logic [BYTE_W-1:0]  win_next [WIN];
    logic [COUNT_W-1:0] seen_next;
    logic               matched;
    logic               hit;
    logic               process;
    logic               found;
    logic               not_found;
    logic               emit;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Result register
    logic               r_out_valid;
    logic               r_out_found;
    logic [COUNT_W-1:0] r_out_offset;

    mbpscan_cfg #(.WIN(WIN)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbpscan_window #(.WIN(WIN)) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_win_next  (win_next),
        .o_seen_next (seen_next),
        .o_matched   (matched)
    );

    mbpscan_match #(.WIN(WIN)) u_match (
        .i_cfg (cfg),
        .i_win (win_next),
        .o_hit (hit)
    );

    // Advance the held byte whenever the result register is free or being taken
    assign process    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || process;

    // Only whole windows count, and only the first match of a scan is reported
    assign found     = !matched && (seen_next >= COUNT_W'(cfg.len)) && hit;
    assign not_found = r_in_last && !matched && !found;
    assign emit      = found || not_found;

    assign step.advance = process;
    assign step.last    = r_in_last;
    assign step.found   = found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.end_of_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && emit) begin
            r_out_found  <= found;
            r_out_offset <= found ? seen_next - COUNT_W'(cfg.len) : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.match_found  = r_out_found;
    assign o_out.match_offset = r_out_offset;

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && emit) |=> r_out_valid)
        else $error("result beat not loaded");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both registers are full");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_offset == '0))
        else $error("not-found beat carries an offset");

    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in_last) |=> !matched)
        else $error("match flag survives end of region");

    a_single_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && matched) |-> !found)
        else $error("second match reported in one scan");

endmodule

// ===== sim/masked_byte_pattern_scanner_test.sv =====
`timescale 1ns / 100ps

// Scanner testbench: bytes go in on one channel and verdicts come out on the
// other. A short table of directed beats comes first, then randomised scans
// under a string of pattern set-ups. Every verdict is checked, against a local
// scanner model of the window, byte count and matched flag or a typed result.
module masked_byte_pattern_scanner_test;
    import mbpscan_pkg::*;

    localparam int PATTERN_MAX   = 16;
    localparam int IDLE_PCT      = 6;     // bubble percent: per receiver cycle, per sent byte
    localparam int SETTLE_CYCLES = 4;     // a verdict lags its byte through the pipe; allow slack
    localparam int TAIL_CYCLES   = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_BYTES   = 140;   // roughly 1850 bytes with the directed table
    localparam int HOLD_PHASE    = 4;     // receiver backs off here
    localparam int CALM_PHASE    = 6;     // no bubbles at all here
    localparam int HOLD_CYCLES   = 250;
    // Longest correct stretch without a beat on either side is the hold-off;
    // take it many times over.
    localparam int STALL_LIMIT   = 4000;

    // Register indexes past the last real register, which the block must drop
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_PATTERN_LEN) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] offset;
    } t_verdict;

    typedef enum logic { ROW_BYTE, ROW_CFG } t_row_op;

    // How a directed byte row is checked
    typedef enum logic [1:0] { BY_MODEL, TYPED_RESULT, TYPED_NONE } t_check;

    typedef enum int { REGION_PLANTED, REGION_SPOILT, REGION_NOISE } t_region;

    typedef struct packed {
        t_row_op              op;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     value;
        logic [BYTE_W-1:0]    data;
        logic                 last;
        t_check               how;
        t_verdict             typed;
    } t_row;

    localparam int ROWS = 31;

    // Directed table. Typed verdicts are the ones that are plain from the
    // set-up: the reset pattern (a single zero byte), a scan shorter than the
    // pattern and the byte after a match.
    localparam t_row DIRECTED [ROWS] = '{
        // Reset set-up: length 1, pattern byte 00, all bytes cared for
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h00, 1'b0, TYPED_RESULT, '{1'b1, 32'd0}},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'hFF, 1'b1, TYPED_NONE,   '{1'b0, 32'd0}},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'hFF, 1'b1, TYPED_RESULT, '{1'b0, 32'd0}},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h00, 1'b1, TYPED_RESULT, '{1'b1, 32'd0}},
        // Three bytes 11 ?? 33 with the middle one a wildcard
        '{ROW_CFG,  CFG_PATTERN_LOW,  64'h0000_0000_0033_2211, 8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_CARE_MASK,    64'h0005, 8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_PATTERN_LEN,  64'd3,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h11, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h99, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h33, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h11, 1'b1, BY_MODEL, '0},
        // Match that completes on the last byte, at a non-zero offset
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h44, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h11, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h33, 1'b1, BY_MODEL, '0},
        // Length zero acts as one; pattern rewritten in the middle of a scan
        '{ROW_CFG,  CFG_PATTERN_LEN,  64'd0,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h22, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_PATTERN_LOW,  64'h33, 8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'h33, 1'b1, BY_MODEL, '0},
        // Oversized length saturates to 16; two bytes can never fill the window
        '{ROW_CFG,  CFG_PATTERN_LEN,  64'd31, 8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_PATTERN_HIGH, '1,     8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_CARE_MASK,    64'd0,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'hFF, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'hFF, 1'b1, TYPED_RESULT, '{1'b0, 32'd0}},
        // Writes to spare indexes must leave the FF FF pattern untouched
        '{ROW_CFG,  CFG_CARE_MASK,    64'hFFFF, 8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_PATTERN_LOW,  '1,     8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_PATTERN_LEN,  64'd2,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_SPARE_FIRST,  64'd0,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_CFG,  CFG_SPARE_LAST,   64'd0,  8'h00, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'hFF, 1'b0, BY_MODEL, '0},
        '{ROW_BYTE, CFG_PATTERN_LOW,  64'd0,  8'hFF, 1'b1, BY_MODEL, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mbpscan_in_if  bytes_if ();
    mbpscan_out_if verdict_if ();

    masked_byte_pattern_scanner #(
        .PATTERN_MAX (PATTERN_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (bytes_if),
        .o_out       (verdict_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Scanner model: registers and scan state
    logic [CFG_W-1:0]   pat_lo;
    logic [CFG_W-1:0]   pat_hi;
    logic [CARE_W-1:0]  care_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [BYTE_W-1:0]  win_bytes [PATTERN_MAX];
    logic [COUNT_W-1:0] seen_count;
    bit                 hit_latched;

    t_verdict    verdicts_due [$];
    int unsigned failures;
    int unsigned bytes_sent;
    int unsigned regions_done;
    int unsigned hits_seen;
    int unsigned misses_seen;
    int          hold_left;    // set once by the stimulus, counted down by the receiver
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned eff_len();
        int unsigned n;
        n = len_reg;
        if (n == 0) n = 1;
        if (n > LEN_MAX) n = LEN_MAX;
        if (n > PATTERN_MAX) n = PATTERN_MAX;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(input int unsigned j);
        logic [PAT_W-1:0] whole;
        whole = {pat_hi, pat_lo};
        return whole[BYTE_W*j +: BYTE_W];
    endfunction

    function automatic void clear_scan();
        foreach (win_bytes[k]) win_bytes[k] = '0;
        seen_count  = '0;
        hit_latched = 1'b0;
    endfunction

    function automatic void model_reset();
        pat_lo   = '0;
        pat_hi   = '0;
        care_reg = '1;
        len_reg  = LEN_W'(1);
        clear_scan();
    endfunction

    // Shift one byte into the window and return 1 when it gives a verdict
    function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input bit last,
                                     output t_verdict v);
        int unsigned n;
        bit          hit;
        bit          produced;
        n        = eff_len();
        produced = 1'b0;
        v        = '0;
        for (int k = PATTERN_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = b;
        if (seen_count != COUNT_SAT) seen_count++;

        if (!hit_latched && seen_count >= n) begin
            hit = 1'b1;
            // Pattern byte j sits n-1-j places back from the newest byte
            for (int unsigned j = 0; j < n; j++) begin
                if (care_reg[j] && pat_byte(j) != win_bytes[n-1-j]) hit = 1'b0;
            end
            if (hit) begin
                hit_latched = 1'b1;
                v.found     = 1'b1;
                v.offset    = seen_count - COUNT_W'(n);
                produced    = 1'b1;
            end
        end

        if (last) begin
            // A scan that never matched still owes a not-found verdict
            if (!produced && !hit_latched) produced = 1'b1;
            clear_scan();
        end
        return produced;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        failures++;
    endtask

    task automatic check_verdict(input logic found, input logic [COUNT_W-1:0] offset);
        t_verdict want;
        if (verdicts_due.size() == 0) begin
            flag_mismatch($sformatf("verdict with nothing due: found=%0b offset=%0d",
                                    found, offset));
        end else begin
            want = verdicts_due.pop_front();
            if (found !== want.found)
                flag_mismatch($sformatf("match_found %0b, expected %0b", found, want.found));
            if (offset !== want.offset)
                flag_mismatch($sformatf("match_offset %0d, expected %0d", offset, want.offset));
            if (want.found) hits_seen++;
            else misses_seen++;
        end
    endtask

    // Receiver: take verdicts, with random bubbles and one long hold-off
    initial begin
        verdict_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (verdict_if.valid && verdict_if.ready)
                check_verdict(verdict_if.match_found, verdict_if.match_offset);
            if (hold_left > 0) begin
                hold_left--;
                verdict_if.ready <= 1'b0;
            end else begin
                verdict_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((bytes_if.valid && bytes_if.ready) || (verdict_if.valid && verdict_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one byte, hold it until taken, then predict its verdict
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last,
                             input t_check how, input t_verdict typed);
        t_verdict v;
        bit       produced;
        bytes_if.valid         <= 1'b1;
        bytes_if.data_byte     <= b;
        bytes_if.end_of_region <= last;
        do @(posedge i_clk); while (!bytes_if.ready);

        produced = scan_byte(b, last, v);
        bytes_sent++;
        if (last) regions_done++;
        case (how)
            BY_MODEL:     if (produced) verdicts_due.push_back(v);
            TYPED_RESULT: verdicts_due.push_back(typed);
            default: ;
        endcase

        // Occasional bubble with valid dropped
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // Write a register once the block has drained, and mirror it in the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        bytes_if.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        // A byte after a match gives no verdict, so allow it to clear the pipe
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PATTERN_LOW:  pat_lo   = value;
            CFG_PATTERN_HIGH: pat_hi   = value;
            CFG_CARE_MASK:    care_reg = value[CARE_W-1:0];
            CFG_PATTERN_LEN:  len_reg  = value[LEN_W-1:0];
            default: ;        // spare index: dropped
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_phase(input int unsigned p);
        logic [LEN_W-1:0]  len;
        logic [CARE_W-1:0] care;
        int unsigned       pick;
        pick = $urandom_range(99);
        care = CARE_W'($urandom);
        case (p)
            0:          begin len = LEN_W'(LEN_MAX); care = '1; end
            1:          begin len = LEN_W'(1);       care = '1; end
            2:          begin len = LEN_W'(LEN_MAX); care = '0; end
            3:                len = '0;
            HOLD_PHASE: begin len = LEN_W'(1);       care = '0; end   // every scan hits at once
            5:                len = '1;
            default: begin
                len = $urandom_range(1) ? LEN_W'($urandom_range(6, 1))
                                        : LEN_W'($urandom_range(31, 0));
                if (pick < 20) care = '1;
                else if (pick < 30) care = '0;
            end
        endcase
        write_reg(CFG_PATTERN_LOW,  {$urandom, $urandom});
        write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
        write_reg(CFG_CARE_MASK,    CFG_W'(care));
        write_reg(CFG_PATTERN_LEN,  CFG_W'(len));
    endtask

    // One scan: random filler, often with the pattern planted somewhere inside
    task automatic run_region(input int unsigned span, input t_region style);
        logic [BYTE_W-1:0] fill [$];
        int unsigned       cared [$];
        int unsigned       n;
        int unsigned       at;
        int unsigned       j;
        n = eff_len();
        for (int unsigned k = 0; k < span; k++) begin
            // Pattern bytes in the filler give near misses
            if (style == REGION_NOISE || $urandom_range(1)) fill.push_back(BYTE_W'($urandom));
            else fill.push_back(pat_byte($urandom_range(n - 1)));
        end
        if (style != REGION_NOISE && span >= n) begin
            at = $urandom_range(span - n);
            for (int unsigned k = 0; k < n; k++) begin
                if (care_reg[k]) begin
                    fill[at+k] = pat_byte(k);
                    cared.push_back(k);
                end
            end
            // Spoil one cared-for byte by a single bit
            if (style == REGION_SPOILT && cared.size() > 0) begin
                j = cared[$urandom_range(cared.size() - 1)];
                fill[at+j] ^= BYTE_W'(1 << $urandom_range(BYTE_W - 1));
            end
        end
        for (int unsigned k = 0; k < span; k++)
            send_byte(fill[k], k == span - 1, BY_MODEL, '0);
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned span;
        int unsigned pick;
        t_region     style;

        bytes_if.valid         <= 1'b0;
        bytes_if.data_byte     <= '0;
        bytes_if.end_of_region <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        i_rst_n                <= 1'b0;
        failures     = 0;
        bytes_sent   = 0;
        regions_done = 0;
        hits_seen    = 0;
        misses_seen  = 0;
        hold_left    = 0;
        calm         = 1'b0;
        model_reset();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < ROWS; r++) begin
            if (DIRECTED[r].op == ROW_CFG)
                write_reg(DIRECTED[r].idx, DIRECTED[r].value);
            else
                send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].how,
                          DIRECTED[r].typed);
        end

        // Random scans, one pattern set-up per phase
        for (int unsigned p = 0; p < PHASES; p++) begin
            setup_phase(p);
            calm = (p == CALM_PHASE);
            // Hold off the receiver so a verdict sits in the output and
            // the input backs up behind it
            if (p == HOLD_PHASE) hold_left = HOLD_CYCLES;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                pick  = $urandom_range(99);
                style = (pick < 65) ? REGION_PLANTED :
                        (pick < 80) ? REGION_SPOILT  : REGION_NOISE;
                span  = ($urandom_range(9) == 0) ? $urandom_range(80, 25)
                                                 : $urandom_range(24, 1);
                run_region(span, style);
            end
        end
        calm = 1'b0;

        // Drain, then give any stray beat time to show up
        bytes_if.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Scanned %0d bytes over %0d regions under %0d pattern set-ups",
                 bytes_sent, regions_done, PHASES + 1);
        $display("Checked %0d found and %0d not-found verdicts, %0d mismatches",
                 hits_seen, misses_seen, failures);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
